// ----- rtl/core/mtf_pkg.sv -----
// Shared types and constants for the move-to-front codec.
package mtf_pkg;

    // Every list entry, input symbol and list position is one byte wide.
    localparam int SYM_W = 8;

    typedef logic [SYM_W-1:0] sym_t;

    // Control broadcast from the top level to every list cell.
    typedef struct packed {
        logic decode;     // Decode mode: match on cell position, not on entry.
        logic start_blk;  // Incoming transaction starts a block: compare against identity.
        logic shift;      // Apply the pending move-to-front this cycle.
        logic shift_blk;  // Pending move-to-front works on the identity list.
        sym_t key;        // Clamped incoming symbol or position.
        sym_t pos;        // List position of the symbol being moved.
    } mtf_ctrl_t;

endpackage

// ----- rtl/core/mtf_cell.sv -----
// One list cell: holds a single list entry, compares it and shifts it back on a move.
module mtf_cell
    import mtf_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  mtf_ctrl_t ctrl,
    input  sym_t      prev_entry,
    output sym_t      entry,
    output sym_t      base,
    output logic      match
);

    localparam sym_t ID      = SYM_W'(IDX);
    localparam sym_t PREV_ID = SYM_W'((IDX == 0) ? 0 : IDX - 1);
    localparam bit   HEAD    = (IDX == 0);

    sym_t entry_reg;
    sym_t entry_next;
    sym_t cur_val;
    sym_t prv_val;

    // Entry as seen by the incoming transaction; a block start sees identity order.
    assign base  = ctrl.start_blk ? ID : entry_reg;
    assign match = ctrl.decode ? (ID == ctrl.key) : (base == ctrl.key);
    assign entry = entry_reg;

    // Move-to-front: cells up to the moved position take the neighbor's entry.
    always_comb
    begin
        cur_val = ctrl.shift_blk ? ID : entry_reg;
        prv_val = (HEAD || !ctrl.shift_blk) ? prev_entry : PREV_ID;
        entry_next = entry_reg;
        if (ctrl.shift)
        begin
            entry_next = (ID <= ctrl.pos) ? prv_val : cur_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= ID;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

// ----- rtl/core/move_to_front_codec_core.sv -----
// Move-to-front codec top level: input and output channels and a row of list cells.
//
// Usage:
//   Input channel (in_valid/in_stall, symbol_in, block_start) carries one byte per
//   transaction. In encode mode the byte is replaced by its list position; in decode
//   mode symbol_in is a list position and the stored byte is returned. Either way the
//   symbol then moves to the list front. block_start restores identity order first.
//   Values at or above ALPHABET_SIZE saturate to ALPHABET_SIZE-1.
//   Output channel (out_valid/out_stall, symbol_out) gives one result per transaction.
//   cfg_we/cfg_data write decode_mode; write it only while the block is idle.
// Timing:
//   A transaction is accepted and the list shift happens in the next cycle; the
//   result passes through res_reg into the output register, which sets out_valid
//   once the receiver is free. No new transaction is taken in the shift cycle; the
//   list cells are busy for the shift cycle after each one.
// Reset:
//   The list returns to identity order and encode mode is selected, at once.
// Stall:
//   A result waiting in the output register does not block the next transaction; a
//   second finished result is held internally and in_stall stays high until it moves.
module move_to_front_codec_core
    import mtf_pkg::*;
#(
    parameter int ALPHABET_SIZE = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] symbol_in,
    input  logic       block_start,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] symbol_out
);

    localparam sym_t MAX_SYM = SYM_W'(ALPHABET_SIZE - 1);

    logic      decode_mode_reg;
    logic      pend_reg;
    logic      hold_reg;
    logic      hold_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    logic      blk_reg;
    sym_t      pos_reg;
    sym_t      sym_reg;
    sym_t      res_reg;
    sym_t      symbol_out_reg;
    sym_t      key;
    sym_t      pos_hit;
    sym_t      sym_hit;
    logic      accept;
    logic      out_free;
    logic      load_out;
    mtf_ctrl_t ctrl;
    sym_t      entry [ALPHABET_SIZE];
    sym_t      base  [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] match;

    // Handshake.
    assign accept     = in_valid && !in_stall;
    assign in_stall   = pend_reg || hold_reg;
    assign out_free   = !out_valid_reg || !out_stall;
    assign load_out   = (pend_reg || hold_reg) && out_free;
    assign out_valid  = out_valid_reg;
    assign symbol_out = symbol_out_reg;

    // Saturate the incoming value to the alphabet.
    assign key = (symbol_in > MAX_SYM) ? MAX_SYM : symbol_in;

    // Broadcast to the cells.
    always_comb
    begin
        ctrl.decode    = decode_mode_reg;
        ctrl.start_blk = block_start;
        ctrl.shift     = pend_reg;
        ctrl.shift_blk = blk_reg;
        ctrl.key       = key;
        ctrl.pos       = pos_reg;
    end

    // The row of cells; cell 0 takes the moved symbol, the rest take their neighbor.
    for (genvar i = 0; i < ALPHABET_SIZE; i++)
    begin : g_cell
        sym_t prev;
        if (i == 0)
        begin : g_head
            assign prev = sym_reg;
        end
        else
        begin : g_body
            assign prev = entry[i-1];
        end
        mtf_cell #(
            .IDX (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .prev_entry (prev),
            .entry      (entry[i]),
            .base       (base[i]),
            .match      (match[i])
        );
    end

    // Exactly one cell matches; collect its position and entry.
    always_comb
    begin
        pos_hit = '0;
        sym_hit = '0;
        for (int i = 0; i < ALPHABET_SIZE; i++)
        begin
            if (match[i])
            begin
                pos_hit = pos_hit | SYM_W'(i);
                sym_hit = sym_hit | base[i];
            end
        end
    end

    // Sequencing of the shift cycle and the output register.
    always_comb
    begin
        hold_next      = (pend_reg || hold_reg) && !out_free;
        out_valid_next = load_out ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_mode_reg <= 1'b0;
            pend_reg        <= 1'b0;
            hold_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                decode_mode_reg <= cfg_data;
            end
            pend_reg      <= accept;
            hold_reg      <= hold_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_reg <= pos_hit;
            sym_reg <= sym_hit;
            res_reg <= decode_mode_reg ? sym_hit : pos_hit;
            blk_reg <= block_start;
        end
        if (load_out)
        begin
            symbol_out_reg <= res_reg;
        end
    end

endmodule

// ----- rtl/core/mtf_checker.sv -----
// Port-level checks for the move-to-front codec, bound to the top level.
module mtf_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] symbol_out
);

    // A stalled result stays on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(symbol_out))
        else $error("stalled output transaction changed or dropped");

    // The cycle after an accepted transaction is the list shift, so input is stalled.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted during list shift cycle");

    // With a free receiver in the shift cycle, the result is loaded and out_valid rises.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
        else $error("result missing two cycles after acceptance");

endmodule

bind move_to_front_codec_core mtf_checker u_mtf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .symbol_out (symbol_out)
);
